FILE: rtl/pgmig_pkg.sv
// Shared types and constants for the PGM sample inverse-gamma block.
// No dependencies; used by every module under rtl/.
package pgmig_pkg;

  localparam int WORK_BITS      = 30;               // Q.30 working precision
  localparam int MUL_W          = WORK_BITS + 1;    // holds values up to 1.0
  localparam int PROD_W         = 2 * MUL_W;
  localparam int NUM_W          = WORK_BITS + 28;   // widest dividend
  localparam int DEN_W          = 27;               // 1099 * 65535 fits
  localparam int CNT_W          = 6;                // divider step counter
  localparam int LIN_W          = 17;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [1:0] REG_MAX_LEVEL   = 2'd0;
  localparam logic [1:0] REG_PIXEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_VALUE_FMT   = 2'd2;

  localparam logic FMT_LEVEL = 1'b0;
  localparam logic FMT_FRAC  = 1'b1;

  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] level;     // effective max level, never zero
    logic        fmt;
    logic [31:0] index;
    logic        clamp;
    logic        last;
  } job_t;

endpackage

FILE: rtl/pgm_sample_inverse_gamma_top.sv
// Top level of the PGM sample inverse-gamma (Rec.709 linearization) block.
// Depends on pgmig_pkg, pgmig_front, pgmig_fifo and pgmig_back.
//
// Raw PGM raster bytes enter one per request on in_*; with max_level above
// 255 two bytes (high first) make one sample, otherwise each byte is one.
// Each sample is clamped to max_level and linearized with the Rec.709
// inverse transfer, then returned as a rounded level or a Q1.FRAC_BITS
// fraction on out_*. After pixel_limit pixels further bytes are swallowed.
// Bytes are taken at one per cycle while the two-entry queue has room; a
// byte that only completes half a sample or is past the limit yields no
// result. On a linear-segment value the back end runs one bit-serial
// NUM_W-step divide; on the power segment it runs the 58-step divide,
// one squaring product, then a 30-step 9th-root search where each step
// runs four products through the single shared 31x31 multiplier, then one
// final product (two for a level result). That shared multiplier and the
// divider set the rate. Config may only be written while idle.
module pgm_sample_inverse_gamma_top import pgmig_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: 0 max_level, 1 pixel_limit, 2 value_format
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // raster byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] raster_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [31:0] pixel_index, [48:32] linear_value
  output logic        out_tuser,   // [0] clamped
  output logic        out_tlast    // last_pixel
);

  logic             push, full, empty, pop;
  job_t             job_w, job_q, res_job;
  logic [LIN_W-1:0] res_val;

  // Queue full is the only input backpressure.
  assign in_tready = !full;

  pgmig_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst_n,
    .cfg_we, .cfg_index, .cfg_wdata,
    .byte_vld (in_tvalid && in_tready),
    .byte_in  (in_tdata),
    .push,
    .job      (job_w)
  );

  pgmig_fifo u_fifo (
    .clk, .rst_n,
    .wr_en   (push),
    .wr_data (job_w),
    .rd_en   (pop),
    .rd_data (job_q),
    .full,
    .empty
  );

  pgmig_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .job_rdy  (!empty),
    .job_in   (job_q),
    .pop,
    .res_vld  (out_tvalid),
    .res_take (out_tready),
    .res_job,
    .res_val
  );

  // Pack the result fields, lowest field first, zero fill to whole bytes.
  assign out_tdata = {7'd0, res_val, res_job.index};
  assign out_tuser = res_job.clamp;
  assign out_tlast = res_job.last;

endmodule

FILE: rtl/pgmig_fifo.sv
// Two-entry request queue between the byte front end and the math back end.
// Depends on pgmig_pkg (job_t).
module pgmig_fifo import pgmig_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_data,
  input  logic rd_en,
  output job_t rd_data,
  output logic full,
  output logic empty
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

FILE: rtl/pgmig_front.sv
// Front end: config registers, byte pairing, clamping and pixel counting.
// Depends on pgmig_pkg; pushes one job_t per complete sample.
module pgmig_front import pgmig_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        byte_vld,
  input  logic [7:0]  byte_in,
  output logic        push,
  output job_t        job
);

  logic [15:0]           max_level_r;
  logic [31:0]           pixel_limit_r;
  logic                  fmt_r;
  logic [7:0]            held_r;
  logic                  phase_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  finished_r;

  logic [32:0]           cap;
  logic [COUNT_BITS-1:0] limit;
  logic [15:0]           lvl;
  logic                  two_byte;
  logic                  stop;
  logic [15:0]           raw;
  logic [COUNT_BITS:0]   count_inc;

  always_comb begin
    cap       = (33'd1 << COUNT_BITS) - 33'd1;
    limit     = ({1'b0, pixel_limit_r} > cap) ? cap[COUNT_BITS-1:0]
                                              : pixel_limit_r[COUNT_BITS-1:0];
    lvl       = (max_level_r == 16'd0) ? 16'd1 : max_level_r;
    two_byte  = (lvl > 16'd255);
    stop      = finished_r || (count_r >= limit);
    raw       = two_byte ? {held_r, byte_in} : {8'd0, byte_in};
    count_inc = {1'b0, count_r} + 1'b1;
    push      = byte_vld && !stop && !(two_byte && !phase_r);
    job.sample = (raw > lvl) ? lvl : raw;
    job.clamp  = (raw > lvl);
    job.level  = lvl;
    job.fmt    = fmt_r;
    job.index  = 32'(count_r);
    job.last   = (count_inc == {1'b0, limit});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r   <= 16'd255;
      pixel_limit_r <= 32'hFFFF_FFFF;
      fmt_r         <= FMT_LEVEL;
      held_r        <= 8'd0;
      phase_r       <= 1'b0;
      count_r       <= '0;
      finished_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_LEVEL:   max_level_r   <= cfg_wdata[15:0];
          REG_PIXEL_LIMIT: pixel_limit_r <= cfg_wdata;
          REG_VALUE_FMT:   fmt_r         <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (byte_vld) begin
        if (stop) begin
          finished_r <= 1'b1;
        end else if (two_byte && !phase_r) begin
          held_r  <= byte_in;
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          count_r <= count_inc[COUNT_BITS-1:0];
          if (count_inc >= {1'b0, limit}) finished_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/pgmig_back.sv
// Back end: bit-serial divider, shared Q.30 multiplier and 9th-root search.
// Depends on pgmig_pkg; pops job_t requests and drives the result channel.
module pgmig_back import pgmig_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_rdy,
  input  job_t        job_in,
  output logic        pop,
  output logic        res_vld,
  input  logic        res_take,
  output job_t        res_job,
  output logic [LIN_W-1:0] res_val
);

  localparam int SHIFT = WORK_BITS - FRAC_BITS;
  localparam logic [MUL_W-1:0] ONE_Q = MUL_W'(1) << WORK_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVD, S_SQR, S_SQRW, S_C2, S_C4, S_C8, S_P, S_CMP,
    S_FIN, S_FINY, S_FINM, S_OUT
  } state_t;

  state_t             state_r;
  job_t               job_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   rem_r, den_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pow_r;
  logic [MUL_W-1:0]   t_r, t2_r, root_r;
  logic [4:0]         bit_r;
  logic [PROD_W-1:0]  prod_r;
  logic [LIN_W-1:0]   res_r;

  logic [MUL_W-1:0]   mul_a, mul_b, prodq, cand;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic               lin_seg;
  logic [NUM_W-1:0]   num_init;
  logic [DEN_W-1:0]   den_init;
  logic [MUL_W:0]     frac_rnd;

  assign prodq = prod_r[WORK_BITS +: MUL_W];
  assign cand  = root_r | (MUL_W'(1) << bit_r);
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign pop    = (state_r == S_IDLE) && job_rdy;
  assign res_vld = (state_r == S_OUT);
  assign res_job = job_r;
  assign res_val = res_r;
  assign frac_rnd = {1'b0, prodq} + ((MUL_W+1)'(1) << (SHIFT - 1));

  // segment select and divider operands for the popped request
  always_comb begin
    lin_seg = (26'(job_in.sample) * 26'd1000) < (26'(job_in.level) * 26'd81);
    if (lin_seg && job_in.fmt == FMT_LEVEL) begin
      num_init = NUM_W'({job_in.sample, 2'b00}) + NUM_W'(9);
      den_init = DEN_W'(18);
    end else if (lin_seg) begin
      num_init = (NUM_W'({job_in.sample, 2'b00}) << FRAC_BITS)
               + NUM_W'(20'(job_in.level) * 20'd9);
      den_init = DEN_W'(job_in.level) * DEN_W'(18);
    end else begin
      num_init = NUM_W'(DEN_W'(job_in.sample) * DEN_W'(1000)
               + DEN_W'(job_in.level) * DEN_W'(99)) << WORK_BITS;
      den_init = DEN_W'(job_in.level) * DEN_W'(1099);
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_SQR:       begin mul_a = t_r;    mul_b = t_r;    end
      S_C2:        begin mul_a = cand;   mul_b = cand;   end
      S_C4, S_C8:  begin mul_a = prodq;  mul_b = prodq;  end
      S_P:         begin mul_a = prodq;  mul_b = cand;   end
      S_FIN:       begin mul_a = t2_r;   mul_b = root_r; end
      S_FINY:      begin mul_a = prodq;  mul_b = MUL_W'(job_r.level); end
      default:     begin mul_a = '0;     mul_b = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_rdy) begin
            job_r   <= job_in;
            pow_r   <= !lin_seg;
            num_r   <= num_init;
            den_r   <= den_init;
            rem_r   <= '0;
            cnt_r   <= CNT_W'(NUM_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          num_r <= {num_r[NUM_W-2:0], ge};
          rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_DIVD;
        end
        S_DIVD: begin
          if (pow_r) begin
            t_r     <= (num_r > NUM_W'(ONE_Q)) ? ONE_Q : num_r[MUL_W-1:0];
            state_r <= S_SQR;
          end else begin
            res_r   <= num_r[LIN_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_SQR: state_r <= S_SQRW;
        S_SQRW: begin
          t2_r <= prodq;
          if (prodq >= ONE_Q) begin
            root_r  <= ONE_Q;
            state_r <= S_FIN;
          end else begin
            root_r  <= '0;
            bit_r   <= 5'(WORK_BITS - 1);
            state_r <= S_C2;
          end
        end
        S_C2: state_r <= S_C4;
        S_C4: state_r <= S_C8;
        S_C8: state_r <= S_P;
        S_P:  state_r <= S_CMP;
        S_CMP: begin
          if (prodq <= t2_r) root_r <= cand;
          bit_r <= bit_r - 1'b1;
          state_r <= (bit_r == '0) ? S_FIN : S_C2;
        end
        S_FIN: state_r <= S_FINY;
        S_FINY: begin
          if (job_r.fmt == FMT_FRAC) begin
            res_r   <= LIN_W'(frac_rnd >> SHIFT);
            state_r <= S_OUT;
          end else begin
            state_r <= S_FINM;
          end
        end
        S_FINM: begin
          res_r   <= LIN_W'((prod_r + (PROD_W'(1) << (WORK_BITS - 1))) >> WORK_BITS);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_take) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
